>>> hdl/dts_pkg.sv
`default_nettype none
package dts_pkg;

   localparam int MaxNodesDefault = 32;
   localparam int MaxEdgesDefault = 128;
   localparam int NodeW = 5;
   localparam int CountW = 6;

   // Command codes carried in the kind field.
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_SORT  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add_edge;     // store the request edge or flag it as dropped
      logic clear_store;  // empty the edge store and clear the drop flag
      logic sort_start;   // clear marks, reset root and depth
      logic root_begin;   // push the current root
      logic root_next;    // advance the root counter
      logic edge_read;    // issue an edge store read at the top cursor
      logic edge_eval;    // evaluate the edge fetched by the last edge_read
      logic emit_push;    // load the output register
   } dts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic roots_done;   // root counter reached the node count
      logic root_finished;// current root is already finished
      logic cursor_end;   // top cursor reached the edge total
      logic eval_push;    // evaluated edge pushes a new node
      logic eval_loop;    // evaluated edge closes a cycle
      logic stack_last;   // the pop empties the stack
      logic out_busy;     // output register still holds a beat
   } dts_stat_type;

endpackage
`default_nettype wire

>>> hdl/dts_ram.sv
`default_nettype none
module dts_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hdl/dts_ctrl.sv
`default_nettype none
module dts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           req_kind,
   input  wire dts_pkg::dts_stat_type stat,
   output dts_pkg::dts_cmd_type      cmd,
   output logic                      emit_node,
   output logic                      emit_last,
   output logic                      emit_loop
);
   import dts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROOT, ST_READ, ST_WAIT, ST_EVAL, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   // Next state and per-cycle commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      emit_node = 1'b0;
      emit_last = 1'b0;
      emit_loop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Any other kind is ignored.
               if (req_kind == KIND_ADD) begin
                  cmd.add_edge = 1'b1;
               end else if (req_kind == KIND_CLEAR) begin
                  cmd.clear_store = 1'b1;
               end else if (req_kind == KIND_SORT) begin
                  cmd.sort_start = 1'b1;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (stat.roots_done) begin
               state_in = ST_DONE;
            end else if (stat.root_finished) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.root_begin = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.cursor_end) begin
               // Top node has no edges left: it finishes.
               if (!stat.out_busy) begin
                  cmd.emit_push = 1'b1;
                  emit_node = 1'b1;
                  if (stat.stack_last) begin
                     cmd.root_next = 1'b1;
                     state_in = ST_ROOT;
                  end
               end
            end else begin
               cmd.edge_read = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (stat.eval_loop) begin
               // The edge read stays on the memory output while the beat waits.
               if (!stat.out_busy) begin
                  cmd.emit_push = 1'b1;
                  emit_last = 1'b1;
                  emit_loop = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.edge_eval = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit_push = 1'b1;
               emit_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/dts_datapath.sv
`default_nettype none
module dts_datapath #(
   parameter int MaxNodes = dts_pkg::MaxNodesDefault,
   parameter int MaxEdges = dts_pkg::MaxEdgesDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [dts_pkg::CountW-1:0] csr_wdata,
   input  wire logic [dts_pkg::NodeW-1:0]  req_from_node,
   input  wire logic [dts_pkg::NodeW-1:0]  req_to_node,
   input  wire dts_pkg::dts_cmd_type       cmd,
   input  wire logic                       emit_node,
   input  wire logic                       emit_last,
   input  wire logic                       emit_loop,
   output dts_pkg::dts_stat_type           stat,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast
);
   import dts_pkg::*;

   localparam int EAW = $clog2(MaxEdges);
   localparam int ETW = $clog2(MaxEdges + 1);
   localparam int SAW = $clog2(MaxNodes);
   localparam int SDW = $clog2(MaxNodes + 1);
   localparam int NW  = $clog2(MaxNodes + 1);

   logic [CountW-1:0] count_ff;
   logic [NW-1:0]     active;
   logic [ETW-1:0]    total_ff;
   logic              drop_ff;
   logic [MaxNodes-1:0] prog_ff, fin_ff;
   logic [NW-1:0]     root_ff;
   logic [SDW-1:0]    depth_ff;
   logic [NodeW-1:0]  snode_ff [MaxNodes];
   logic [ETW-1:0]    scur_ff [MaxNodes];
   logic [SAW-1:0]    top;
   logic [NodeW-1:0]  v;
   logic [ETW-1:0]    e;
   logic [2*NodeW-1:0] rd_data;
   logic [NodeW-1:0]  w_from, w_to;
   logic              w_ok, w_fin, w_prog;
   logic              store_ok;

   // Effective node count, saturated at MaxNodes.
   assign active = (32'(count_ff) > MaxNodes) ? NW'(MaxNodes) : NW'(count_ff);
   assign top = SAW'(depth_ff - SDW'(1));
   assign v = snode_ff[top];
   assign e = scur_ff[top];
   assign store_ok = (NW'(req_from_node) < active) && (NW'(req_to_node) < active)
      && (total_ff < ETW'(MaxEdges));

   dts_ram #(.Width(2 * NodeW), .Depth(MaxEdges)) u_edges (
      .clock  (clock),
      .wr_en  (cmd.add_edge && store_ok),
      .wr_addr(EAW'(total_ff)),
      .wr_data({req_to_node, req_from_node}),
      .rd_addr(EAW'(e)),
      .rd_data(rd_data)
   );

   assign w_from = rd_data[NodeW-1:0];
   assign w_to   = rd_data[2*NodeW-1:NodeW];
   assign w_ok   = (w_from == v) && (NW'(w_to) < active);
   assign w_fin  = fin_ff[SAW'(w_to)];
   assign w_prog = prog_ff[SAW'(w_to)];

   // Status toward the controller.
   always_comb begin
      stat.roots_done    = (root_ff >= active);
      stat.root_finished = fin_ff[SAW'(root_ff)];
      stat.cursor_end    = (e >= total_ff);
      stat.eval_push     = w_ok && !w_fin && !w_prog;
      stat.eval_loop     = w_ok && !w_fin && w_prog;
      stat.stack_last    = (depth_ff == SDW'(1));
      stat.out_busy      = rsp_tvalid && !rsp_tready;
   end

   // Configuration, edge count and drop flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         if (csr_we) count_ff <= csr_wdata;
         if (cmd.clear_store) begin
            total_ff <= '0;
            drop_ff  <= 1'b0;
         end else if (cmd.add_edge) begin
            if (store_ok) total_ff <= total_ff + ETW'(1);
            else drop_ff <= 1'b1;
         end
      end
   end

   // Walk state: marks, root counter and stack.
   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff  <= '0;
         fin_ff   <= '0;
         root_ff  <= '0;
         depth_ff <= '0;
      end else begin
         if (cmd.sort_start) begin
            prog_ff  <= '0;
            fin_ff   <= '0;
            root_ff  <= '0;
            depth_ff <= '0;
         end
         if (cmd.root_next) root_ff <= root_ff + NW'(1);
         if (cmd.root_begin) begin
            snode_ff[0] <= NodeW'(root_ff);
            scur_ff[0]  <= '0;
            prog_ff[SAW'(root_ff)] <= 1'b1;
            depth_ff <= SDW'(1);
         end
         if (cmd.edge_eval) begin
            if (w_ok) begin
               scur_ff[top] <= e + ETW'(1);
               if (!w_fin && !w_prog && (depth_ff < SDW'(MaxNodes))) begin
                  snode_ff[SAW'(depth_ff)] <= w_to;
                  scur_ff[SAW'(depth_ff)]  <= '0;
                  depth_ff <= depth_ff + SDW'(1);
                  prog_ff[SAW'(w_to)] <= 1'b1;
               end
            end else begin
               scur_ff[top] <= e + ETW'(1);
            end
         end
         if (cmd.emit_push && emit_node) begin
            prog_ff[SAW'(v)] <= 1'b0;
            fin_ff[SAW'(v)]  <= 1'b1;
            depth_ff <= depth_ff - SDW'(1);
         end
      end
   end

   // Output register; a loop beat takes its node from the edge on the memory output.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.emit_push) begin
         rsp_tvalid <= 1'b1;
         rsp_tlast  <= emit_last;
         rsp_tdata  <= {2'b00, drop_ff,
            emit_loop ? w_to : NodeW'(0),
            emit_loop, emit_last, emit_node ? v : NodeW'(0), emit_node};
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end
endmodule
`default_nettype wire

>>> hdl/dfs_topological_sort.sv
`default_nettype none
// Depth-first topological sort engine. Each req beat is a command: add edge
// (one beat a cycle), run sort, or clear the edge store. A sort emits one rsp
// beat per finished node in post-order and a final status beat with tlast,
// which also reports a detected cycle. A sort holds req_tready low; for each
// node on the walk stack it scans the stored edges one at a time through the
// single read port of the edge memory, reading, waiting and then evaluating each.
module dfs_topological_sort #(
   parameter int MaxNodes = dts_pkg::MaxNodesDefault,
   parameter int MaxEdges = dts_pkg::MaxEdgesDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [dts_pkg::CountW-1:0] csr_wdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // kind[1:0], from_node[6:2], to_node[11:7], zero fill
   input  wire logic [15:0]                req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // has_node[0], node_index[5:1], loop_found[6], loop_node[11:7],
   // edge_dropped[12], zero fill; is_last travels as tlast
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast
);
   import dts_pkg::*;

   dts_cmd_type  cmd;
   dts_stat_type stat;
   logic emit_node, emit_last, emit_loop;
   logic [15:0] raw;

   dts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_kind(req_tdata[1:0]), .stat(stat),
      .cmd(cmd), .emit_node(emit_node), .emit_last(emit_last),
      .emit_loop(emit_loop)
   );

   dts_datapath #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_from_node(req_tdata[6:2]), .req_to_node(req_tdata[11:7]),
      .cmd(cmd), .emit_node(emit_node), .emit_last(emit_last),
      .emit_loop(emit_loop), .stat(stat), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(raw), .rsp_tlast(rsp_tlast)
   );

   // Drop the internal is_last bit from the packed data; it is on tlast.
   assign rsp_tdata = {3'b000, raw[13:7], raw[5:0]};
endmodule
`default_nettype wire

>>> hdl/dts_checker.sv
`default_nettype none
module dts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   // A stalled beat keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // Node beats never carry the loop flag or tlast.
   a_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tlast && !rsp_tdata[6])
      else $error("node beat with status bits");

   // Status beats carry no node.
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[5:0] == 6'd0)
      else $error("status beat with node");

   // Loop node is zero unless the loop flag is set.
   a_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tdata[11:7] == 5'd0)
      else $error("loop node without loop flag");

   // A beat still waiting when a command is accepted is a status beat.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("node beat pending while commands are accepted");
endmodule

bind dfs_topological_sort dts_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
   .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
`default_nettype wire
